/* design/rdd_pkg.sv */
package rdd_pkg;

  // Field widths fixed by the item format
  localparam int UNIT_W     = 16;
  localparam int IDX_W      = 3;
  localparam int MASK_W     = 8;
  localparam int CNT_W      = 4;
  localparam int CLASS_MAX  = 3;
  localparam int SLOT_LIMIT = 8;

  // Parameter defaults
  localparam int NUM_PROCESSES_DEF    = 8;
  localparam int RESOURCE_CLASSES_DEF = 3;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd5;
  localparam logic [0:0] REG_PROCESS_COUNT = 1'b0;

  // Result kinds
  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_AVAIL = 2'd0,
    CMD_LOAD_ROW   = 2'd1,
    CMD_RUN        = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_avail;
    logic load_row;
    logic scan;
    logic emit;
  } rdd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic found;
    logic out_full;
  } rdd_status_t;

  typedef logic [CLASS_MAX-1:0][UNIT_W-1:0] vec_t;

  // Number of slots that can ever take part in a run
  function automatic int slot_count(input int n);
    return (n < SLOT_LIMIT) ? n : SLOT_LIMIT;
  endfunction

endpackage

/* design/resource_deadlock_detector.sv */
// Resource deadlock detector.
// Input channel (in_valid/in_ready) takes one command item: load the
// available vector, load one process slot's allocation and request rows
// (which also clears its finished mark), or run detection.
// Output channel (out_valid/out_ready) delivers results of a run: one
// release item per freed slot (kind 0, slot index, free vector after it),
// then one verdict (kind 1, last 1) with the mask of unfinished slots.
// Loads are written as they are accepted. A run alternates a scan step and
// an emit step for each result; its first result is registered by the emit
// step that follows the first scan. The scan checks all slots at once; the
// emit step adds back the selected allocation.
// The result register decouples the two sides: new items are taken while
// the verdict waits. When the receiver stalls, the run pauses in its emit
// step until the result register frees up.
// process_count lies at APB address 0; counts above the slot limit saturate.
// Synchronous reset clears the available vector and all slot valid and
// finished marks (row tables keep their contents), and sets process_count to 5.
module resource_deadlock_detector
  import rdd_pkg::*;
#(
  parameter int NUM_PROCESSES    = NUM_PROCESSES_DEF,
  parameter int RESOURCE_CLASSES = RESOURCE_CLASSES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [IDX_W-1:0]      process_index,
  input  logic [UNIT_W-1:0]     avail_0,
  input  logic [UNIT_W-1:0]     avail_1,
  input  logic [UNIT_W-1:0]     avail_2,
  input  logic [UNIT_W-1:0]     alloc_0,
  input  logic [UNIT_W-1:0]     alloc_1,
  input  logic [UNIT_W-1:0]     alloc_2,
  input  logic [UNIT_W-1:0]     request_0,
  input  logic [UNIT_W-1:0]     request_1,
  input  logic [UNIT_W-1:0]     request_2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [IDX_W-1:0]      released_process,
  output logic [MASK_W-1:0]     deadlocked_mask,
  output logic [UNIT_W-1:0]     free_0,
  output logic [UNIT_W-1:0]     free_1,
  output logic [UNIT_W-1:0]     free_2,
  output logic                  last
);

  localparam int SLOTS = slot_count(NUM_PROCESSES);

  logic [CNT_W-1:0] process_count;
  logic [CNT_W-1:0] count_eff;
  logic             reg_sel;
  rdd_cmd_t         cmd;
  rdd_status_t      status;
  vec_t             free_vec;

  // Register access
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_PROCESS_COUNT;
  assign prdata  = reg_sel ? APB_DATA_W'(process_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      process_count <= pwdata[CNT_W-1:0];
    end
  end

  // Clamp the count to the available slots
  assign count_eff = (process_count > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : process_count;

  assign free_0 = free_vec[0];
  assign free_1 = free_vec[1];
  assign free_2 = free_vec[2];

  rdd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdd_dpath #(
    .NUM_PROCESSES    (NUM_PROCESSES),
    .RESOURCE_CLASSES (RESOURCE_CLASSES)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .count_eff        (count_eff),
    .process_index    (process_index),
    .avail_in         ({avail_2, avail_1, avail_0}),
    .alloc_in         ({alloc_2, alloc_1, alloc_0}),
    .request_in       ({request_2, request_1, request_0}),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .kind             (kind),
    .released_process (released_process),
    .deadlocked_mask  (deadlocked_mask),
    .free_out         (free_vec),
    .last             (last)
  );

endmodule

/* design/rdd_ctrl.sv */
module rdd_ctrl
  import rdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic              out_ready,
  input  rdd_status_t       status,
  output rdd_cmd_t          cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !status.out_full || out_ready;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode items and sequence the scan and emit steps of a run
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (command)
            CMD_LOAD_AVAIL: cmd.load_avail = 1'b1;
            CMD_LOAD_ROW:   cmd.load_row = 1'b1;
            CMD_RUN:        state_next = ST_SCAN;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.found ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/rdd_dpath.sv */
module rdd_dpath
  import rdd_pkg::*;
#(
  parameter int NUM_PROCESSES    = NUM_PROCESSES_DEF,
  parameter int RESOURCE_CLASSES = RESOURCE_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rdd_cmd_t          cmd,
  output rdd_status_t       status,
  input  logic [CNT_W-1:0]  count_eff,
  input  logic [IDX_W-1:0]  process_index,
  input  vec_t              avail_in,
  input  vec_t              alloc_in,
  input  vec_t              request_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              kind,
  output logic [IDX_W-1:0]  released_process,
  output logic [MASK_W-1:0] deadlocked_mask,
  output vec_t              free_out,
  output logic              last
);

  localparam int SLOTS = slot_count(NUM_PROCESSES);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [UNIT_W-1:0] avail     [RESOURCE_CLASSES];
  logic [UNIT_W-1:0] alloc_tab [SLOTS][RESOURCE_CLASSES];
  logic [UNIT_W-1:0] req_tab   [SLOTS][RESOURCE_CLASSES];
  logic [UNIT_W:0]   sum       [RESOURCE_CLASSES];
  logic [UNIT_W-1:0] avail_rel [RESOURCE_CLASSES];
  logic [SLOTS-1:0]  row_valid;
  logic [SLOTS-1:0]  finished;
  logic [SLOTS-1:0]  active;
  logic [SLOTS-1:0]  fit;
  logic              fit_any;
  logic [SW-1:0]     fit_idx;
  logic              found;
  logic [SW-1:0]     sel;
  logic              row_ok;
  logic [SW-1:0]     row_idx;

  assign status.found    = found;
  assign status.out_full = out_valid;

  assign row_ok  = {1'b0, process_index} < CNT_W'(SLOTS);
  assign row_idx = process_index[SW-1:0];

  // Check every slot against the available vector in parallel
  always_comb begin
    for (int p = 0; p < SLOTS; p++) begin
      active[p] = count_eff > CNT_W'(p);
      fit[p]    = active[p] && !finished[p];
      for (int k = 0; k < RESOURCE_CLASSES; k++) begin
        if (row_valid[p] && (req_tab[p][k] > avail[k])) begin
          fit[p] = 1'b0;
        end
      end
    end
  end

  // Pick the lowest-numbered qualifying slot
  always_comb begin
    fit_any = |fit;
    fit_idx = '0;
    for (int p = SLOTS - 1; p >= 0; p--) begin
      if (fit[p]) begin
        fit_idx = SW'(p);
      end
    end
  end

  // Return the released slot's allocation, saturating
  always_comb begin
    for (int k = 0; k < RESOURCE_CLASSES; k++) begin
      sum[k] = {1'b0, avail[k]}
             + {1'b0, (row_valid[sel] ? alloc_tab[sel][k] : {UNIT_W{1'b0}})};
      avail_rel[k] = sum[k][UNIT_W] ? {UNIT_W{1'b1}} : sum[k][UNIT_W-1:0];
    end
  end

  // Control state: available vector, marks, scan result, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RESOURCE_CLASSES; k++) begin
        avail[k] <= '0;
      end
      row_valid <= '0;
      finished  <= '0;
      found     <= 1'b0;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_avail) begin
        for (int k = 0; k < RESOURCE_CLASSES; k++) begin
          avail[k] <= avail_in[k];
        end
      end
      if (cmd.load_row && row_ok) begin
        row_valid[row_idx] <= 1'b1;
        finished[row_idx]  <= 1'b0;
      end
      if (cmd.scan) begin
        found <= fit_any;
        sel   <= fit_idx;
      end
      if (cmd.emit && found) begin
        for (int k = 0; k < RESOURCE_CLASSES; k++) begin
          avail[k] <= avail_rel[k];
        end
        finished[sel] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Write one slot's rows
  always_ff @(posedge clk) begin
    if (cmd.load_row && row_ok) begin
      for (int k = 0; k < RESOURCE_CLASSES; k++) begin
        alloc_tab[row_idx][k] <= alloc_in[k];
        req_tab[row_idx][k]   <= request_in[k];
      end
    end
  end

  // Load the result register; unused classes read as zero
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind             <= found ? KIND_RELEASE : KIND_VERDICT;
      last             <= found ? KIND_RELEASE : KIND_VERDICT;
      released_process <= found ? IDX_W'(sel) : '0;
      deadlocked_mask  <= found ? '0 : MASK_W'(active & ~finished);
      for (int k = 0; k < CLASS_MAX; k++) begin
        if (k < RESOURCE_CLASSES) begin
          free_out[k] <= found ? avail_rel[k] : avail[k];
        end else begin
          free_out[k] <= '0;
        end
      end
    end
  end

endmodule

/* design/rdd_checker.sv */
module rdd_checker
  import rdd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              pready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              kind,
  input logic [IDX_W-1:0]  released_process,
  input logic [MASK_W-1:0] deadlocked_mask,
  input logic [UNIT_W-1:0] free_0,
  input logic [UNIT_W-1:0] free_1,
  input logic [UNIT_W-1:0] free_2,
  input logic              last
);

  // The verdict is the only item that ends a run
  a_last_is_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == kind))
    else $error("last does not match kind");

  // A verdict names no slot
  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_VERDICT) |-> (released_process == '0))
    else $error("verdict carries a slot index");

  // A release carries no deadlock mask
  a_release_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RELEASE) |-> (deadlocked_mask == '0))
    else $error("release carries a deadlock mask");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind)
      && $stable(released_process) && $stable(deadlocked_mask)
      && $stable(free_0) && $stable(free_1) && $stable(free_2)))
    else $error("stalled result changed");

  // The register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind resource_deadlock_detector rdd_checker u_rdd_checker (
  .clk              (clk),
  .rst              (rst),
  .pready           (pready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .kind             (kind),
  .released_process (released_process),
  .deadlocked_mask  (deadlocked_mask),
  .free_0           (free_0),
  .free_1           (free_1),
  .free_2           (free_2),
  .last             (last)
);
